@@ hw/rtl/eia_pkg.sv @@
// Shared types and codes for the entity id allocator.
package eia_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_SET_SIG = 2'd2,
    OP_GET_SIG = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic pop;
    logic push;
  } queue_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

@@ hw/rtl/eia_free_queue.sv @@
// Free id queue: ring memory with head, tail and fill count, plus write forwarding.
module eia_free_queue #(
  parameter int NUM_IDS = 256,
  parameter int ID_W    = 8,
  parameter int CNT_W   = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  eia_pkg::queue_cmd_t  cmd,
  input  logic [ID_W-1:0]      push_id,
  output logic [ID_W-1:0]      head_id,
  output eia_pkg::queue_stat_t stat
);
  import eia_pkg::*;

  localparam logic [ID_W-1:0]  LastSlot = ID_W'(NUM_IDS - 1);
  localparam logic [CNT_W-1:0] FullCnt  = CNT_W'(NUM_IDS);

  logic [ID_W-1:0]  mem [NUM_IDS];
  logic [ID_W-1:0]  rdata;
  logic [ID_W-1:0]  raddr;
  logic [ID_W-1:0]  head;
  logic [ID_W-1:0]  head_next;
  logic [ID_W-1:0]  tail;
  logic [ID_W-1:0]  tail_next;
  logic [CNT_W-1:0] fill;
  logic             wrapped;
  logic             fwd_valid;
  logic [ID_W-1:0]  fwd_addr;
  logic [ID_W-1:0]  fwd_data;

  // Slots never written since reset read back as their own index.
  always_comb begin
    head_next = head;
    if (cmd.pop) begin
      head_next = (head == LastSlot) ? '0 : head + 1'b1;
    end
    tail_next = (tail == LastSlot) ? '0 : tail + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= FullCnt;
      wrapped   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      head <= head_next;
      if (cmd.push) begin
        tail <= tail_next;
        if (tail == LastSlot) begin
          wrapped <= 1'b1;
        end
      end
      if (cmd.push && !cmd.pop) begin
        fill <= fill + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        fill <= fill - 1'b1;
      end
      if (rd_en) begin
        fwd_valid <= cmd.push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_id;
    end
    if (rd_en) begin
      rdata    <= mem[head_next];
      raddr    <= head_next;
      fwd_addr <= tail;
      fwd_data <= push_id;
    end
  end

  always_comb begin
    if (fwd_valid && (fwd_addr == raddr)) begin
      head_id = fwd_data;
    end else if (!wrapped && (raddr >= tail)) begin
      head_id = raddr;
    end else begin
      head_id = rdata;
    end
    stat.empty = (fill == '0);
    stat.full  = (fill == FullCnt);
  end

endmodule

@@ hw/rtl/eia_sig_table.sv @@
// Signature table: one word per id, cleared by a sweep after reset, with write forwarding.
module eia_sig_table #(
  parameter int NUM_IDS  = 256,
  parameter int ID_W     = 8,
  parameter int SIG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ID_W-1:0]     rd_addr,
  input  logic                wr_en,
  input  logic [ID_W-1:0]     wr_addr,
  input  logic [SIG_BITS-1:0] wr_data,
  output logic [SIG_BITS-1:0] rd_data,
  output logic                busy
);

  localparam logic [ID_W-1:0] LastSlot = ID_W'(NUM_IDS - 1);

  logic [SIG_BITS-1:0] mem [NUM_IDS];
  logic [SIG_BITS-1:0] rdata;
  logic [ID_W-1:0]     raddr;
  logic [ID_W-1:0]     clr_addr;
  logic                fwd_valid;
  logic [ID_W-1:0]     fwd_addr;
  logic [SIG_BITS-1:0] fwd_data;
  logic                mem_we;
  logic [ID_W-1:0]     mem_waddr;
  logic [SIG_BITS-1:0] mem_wdata;

  always_comb begin
    if (busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LastSlot) begin
          busy <= 1'b0;
        end
      end
      if (rd_en) begin
        fwd_valid <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata    <= mem[rd_addr];
      raddr    <= rd_addr;
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  assign rd_data = (fwd_valid && (fwd_addr == raddr)) ? fwd_data : rdata;

endmodule

@@ hw/rtl/entity_id_allocator.sv @@
// Top level of the entity id allocator: request stage, decision logic and result register.
//
// Usage: each request word (opcode, entity_id, signature_in) enters on the in_valid /
// in_ready channel and produces exactly one result word (status, id_out, signature_out,
// live_count) on the out_valid / out_ready channel, in request order.
// A create pops the oldest free id, a destroy pushes an id back, set / get write or read
// the signature word of an id. Other ops on out-of-range ids give ST_RANGE, change nothing.
// The accepting edge loads the request register together with the synchronous reads of
// the free queue and signature memories, and the result register is loaded when the
// request stage advances. Throughput is one word per cycle while the receiver keeps
// out_ready high; reads that hit the slot written by the word just ahead are forwarded,
// so back-to-back words see each other's effects.
// After reset the signature memory is swept to zero, one entry per cycle, and in_ready
// stays low during that sweep. The free queue needs no sweep, since a slot that was never
// written reads as its own index.
// When the receiver stalls, the result register holds its word, the request register
// holds the next one, and in_ready drops until out_ready frees the result register.
module entity_id_allocator #(
  parameter int NUM_IDS  = 256,
  parameter int SIG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [8:0]  entity_id,
  input  logic [31:0] signature_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  id_out,
  output logic [31:0] signature_out,
  output logic [8:0]  live_count
);
  import eia_pkg::*;

  localparam int ID_W  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int CNT_W = $clog2(NUM_IDS + 1);
  localparam logic [CNT_W-1:0] MaxLive = CNT_W'(NUM_IDS);

  // Request stage registers.
  logic                s1_valid;
  op_t                 s1_op;
  logic                s1_in_range;
  logic [ID_W-1:0]     s1_idx;
  logic [SIG_BITS-1:0] s1_sig;

  logic [CNT_W-1:0]    living_total;
  logic [CNT_W-1:0]    living_total_next;

  logic                accept;
  logic                advance;
  logic [31:0]         eid_wide;
  logic                in_range;
  logic [63:0]         sig_in_wide;

  queue_cmd_t          q_cmd;
  queue_stat_t         q_stat;
  logic [ID_W-1:0]     head_id;

  logic                tbl_busy;
  logic                tbl_we;
  logic [ID_W-1:0]     tbl_waddr;
  logic [SIG_BITS-1:0] tbl_wdata;
  logic [SIG_BITS-1:0] tbl_rdata;

  status_t             status_next;
  logic [ID_W-1:0]     id_next;
  logic [SIG_BITS-1:0] sig_out_next;
  logic [31:0]         id_wide;
  logic [63:0]         sig_out_wide;
  logic [31:0]         live_wide;

  // The request stage moves on whenever the result register is empty or being emptied.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !tbl_busy && (!s1_valid || advance);
  assign accept   = in_valid && in_ready;

  assign eid_wide    = 32'(entity_id);
  assign in_range    = (eid_wide < 32'(NUM_IDS));
  assign sig_in_wide = 64'(signature_in);

  eia_free_queue #(
    .NUM_IDS (NUM_IDS),
    .ID_W    (ID_W),
    .CNT_W   (CNT_W)
  ) u_free_queue (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .cmd     (q_cmd),
    .push_id (s1_idx),
    .head_id (head_id),
    .stat    (q_stat)
  );

  eia_sig_table #(
    .NUM_IDS  (NUM_IDS),
    .ID_W     (ID_W),
    .SIG_BITS (SIG_BITS)
  ) u_sig_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (eid_wide[ID_W-1:0]),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_data (tbl_rdata),
    .busy    (tbl_busy)
  );

  // Decision logic for the word in the request stage. Every state change is gated by
  // advance, so a stalled word leaves the queue, the table and the live count untouched.
  always_comb begin
    status_next       = ST_OK;
    id_next           = '0;
    sig_out_next      = '0;
    living_total_next = living_total;
    q_cmd             = '0;
    tbl_we            = 1'b0;
    tbl_waddr         = s1_idx;
    tbl_wdata         = '0;
    unique case (s1_op)
      OP_CREATE: begin
        if (q_stat.empty) begin
          status_next = ST_EMPTY;
        end else begin
          id_next    = head_id;
          q_cmd.pop  = advance;
          tbl_we     = advance;
          tbl_waddr  = head_id;
          if (living_total != MaxLive) begin
            living_total_next = living_total + 1'b1;
          end
        end
      end
      OP_DESTROY: begin
        if (!s1_in_range) begin
          status_next = ST_RANGE;
        end else if (q_stat.full) begin
          status_next = ST_FULL;
        end else begin
          q_cmd.push = advance;
          tbl_we     = advance;
          if (living_total != '0) begin
            living_total_next = living_total - 1'b1;
          end
        end
      end
      OP_SET_SIG: begin
        if (!s1_in_range) begin
          status_next = ST_RANGE;
        end else begin
          tbl_we    = advance;
          tbl_wdata = s1_sig;
        end
      end
      OP_GET_SIG: begin
        if (!s1_in_range) begin
          status_next = ST_RANGE;
        end else begin
          sig_out_next = tbl_rdata;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign id_wide      = 32'(id_next);
  assign sig_out_wide = 64'(sig_out_next);
  assign live_wide    = 32'(living_total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      living_total <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid    <= 1'b1;
        living_total <= living_total_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op_t'(opcode);
      s1_in_range <= in_range;
      s1_idx      <= eid_wide[ID_W-1:0];
      s1_sig      <= sig_in_wide[SIG_BITS-1:0];
    end
    if (advance) begin
      status        <= status_next;
      id_out        <= id_wide[7:0];
      signature_out <= sig_out_wide[31:0];
      live_count    <= live_wide[8:0];
    end
  end

endmodule
